### sv/adsr_pkg.sv
// shared types and constants for the adsr square wave generator
package adsr_pkg;

	typedef enum logic [2:0] {
		ST_OFF     = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_MUL,
		SQ_PRE,
		SQ_DIV,
		SQ_ENV,
		SQ_RAMP,
		SQ_FIN
	} seq_t;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE   = 3'd4;

	// three times the positive and negative full-scale magnitudes
	localparam int K_W = 33;
	localparam logic [K_W-1:0] K_POS = 33'd6442450941;
	localparam logic [K_W-1:0] K_NEG = 33'd6442450944;

	localparam int QMW  = 32;
	localparam int CNTW = 6;

endpackage

### sv/adsr_square_wave_generator_top.sv
// square wave generator with linear adsr envelope, bit-serial multiply and divide
// A tick word yields one signed sample followed by one envelope step; a set-stage
// word with a stage code up to release changes the envelope stage and yields
// nothing; other codes are ignored. A set-stage word leaves the sequencer idle. A
// tick runs a multiply, a prepare step and a divide for the sample, then an envelope
// step; when the stage ramps, a multiply, a prepare step, a divide and a ramp step
// follow; last the output register is loaded. A zero attack takes the envelope step
// twice, falling through into decay. The time is set by the single shared shift-add
// multiplier (one multiplier bit a cycle) and the restoring divider (one quotient
// bit a cycle) that serve both the sample scaling and the ramp ratio. A word is
// taken while a sample sits in the output register, not while one waits to load.
module adsr_square_wave_generator_top #(
	parameter int LEVEL_BITS    = 16,
	parameter int DURATION_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // new_stage
	input  logic                           s_tuser,   // func
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [39:0]                    m_tdata,   // sample, stage
	input  logic                           cfg_wen,
	input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import adsr_pkg::*;

	localparam int LB  = LEVEL_BITS;
	localparam int DB  = DURATION_BITS;
	localparam int LW  = LB + 1;
	localparam int MBW = (DB > K_W) ? DB : K_W;
	localparam int PW  = LW + MBW;
	localparam int VW  = (DB > LB + 4) ? DB : LB + 4;
	localparam int SW  = (LW > 17) ? LW : 17;

	localparam logic [LW-1:0] FULL       = {1'b1, {LB{1'b0}}};
	localparam logic [VW-1:0] SAMPLE_DIV = VW'(64'd10 << LB);

	seq_t state_q, state_d;

	logic [DB-1:0] att_q, dec_q, rel_q;
	logic [16:0]   sus_q;
	logic [31:0]   step_q;

	stage_t        stage_q;
	logic [LW-1:0] level_q;
	logic [LW-1:0] start_q;
	logic [DB-1:0] elapsed_q;
	logic [31:0]   phase_q;

	logic            op_ramp_q;
	logic            neg_q;
	logic            r_add_q;
	logic            r_end_q;
	stage_t          r_next_q;
	logic [CNTW-1:0] cnt_q;
	logic            m_valid_q;

	logic [LW-1:0]  mr_q;
	logic [MBW-1:0] mc_q;
	logic [PW-1:0]  p_q;
	logic [VW-1:0]  dv_q;
	logic [VW-1:0]  rem_q;
	logic [QMW-1:0] qs_q;
	logic [31:0]    sample_q;
	logic [34:0]    m_data_q;

	logic [DB-1:0] dur_w;
	logic [DB-1:0] dur;
	logic [DB-1:0] e_inc;
	logic [DB-1:0] e_use;
	logic          e_end;
	logic [LW-1:0] span;
	logic          add;
	stage_t        nxt;
	logic          ramp_go;
	logic [SW-1:0] sus_ext;
	logic [LW-1:0] sus_lvl;
	logic [VW:0]   trial;
	logic          ge;
	logic [LW-1:0] q_lvl;
	logic [LW-1:0] lvl_new;
	logic          accept;
	logic          out_load;
	logic [2:0]    ns;

	assign dur_w   = DB'({8'h00, cfg_data[23:0]});
	assign sus_ext = SW'(sus_q);
	assign sus_lvl = (sus_ext > SW'(FULL)) ? FULL : LW'(sus_ext);
	assign e_inc   = (&elapsed_q) ? elapsed_q : elapsed_q + DB'(1);
	assign e_end   = e_inc >= dur;
	assign e_use   = (e_inc > dur) ? dur : e_inc;
	assign trial   = {rem_q, qs_q[QMW-1]};
	assign ge      = trial >= {1'b0, dv_q};
	assign q_lvl   = qs_q[LW-1:0];
	assign lvl_new = r_add_q ? start_q + q_lvl : start_q - q_lvl;
	assign accept  = s_tvalid && s_tready;
	assign ns      = s_tdata[2:0];
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b00000, m_data_q};

	always_comb begin
		dur  = '0;
		span = '0;
		add  = 1'b0;
		nxt  = stage_q;
		unique case (stage_q)
			ST_ATTACK: begin
				dur  = att_q;
				span = FULL - start_q;
				add  = 1'b1;
				nxt  = ST_DECAY;
			end
			ST_DECAY: begin
				dur = dec_q;
				nxt = ST_SUSTAIN;
				if (start_q >= sus_lvl) begin
					span = start_q - sus_lvl;
				end else begin
					span = sus_lvl - start_q;
					add  = 1'b1;
				end
			end
			ST_RELEASE: begin
				dur  = rel_q;
				span = start_q;
				nxt  = ST_OFF;
			end
			default: begin
				dur = '0;
			end
		endcase
		ramp_go = (stage_q == ST_ATTACK || stage_q == ST_DECAY || stage_q == ST_RELEASE)
			&& (dur != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			SQ_IDLE: begin
				s_tready = 1'b1;
				if (accept && !s_tuser) begin
					state_d = SQ_MUL;
				end
			end
			SQ_MUL: begin
				if (cnt_q == CNTW'(1)) begin
					state_d = SQ_PRE;
				end
			end
			SQ_PRE: begin
				state_d = SQ_DIV;
			end
			SQ_DIV: begin
				if (cnt_q == CNTW'(1)) begin
					state_d = op_ramp_q ? SQ_RAMP : SQ_ENV;
				end
			end
			SQ_ENV: begin
				priority if (ramp_go) begin
					state_d = SQ_MUL;
				end else if (stage_q == ST_ATTACK) begin
					state_d = SQ_ENV;
				end else begin
					state_d = SQ_FIN;
				end
			end
			SQ_RAMP: begin
				state_d = SQ_FIN;
			end
			SQ_FIN: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	// configuration, envelope state and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q     <= DB'(32'd960);
			dec_q     <= DB'(32'd960);
			rel_q     <= DB'(32'd38400);
			sus_q     <= 17'd65536;
			step_q    <= 32'd4921317;
			stage_q   <= ST_OFF;
			level_q   <= '0;
			start_q   <= '0;
			elapsed_q <= '0;
			phase_q   <= '0;
			op_ramp_q <= 1'b0;
			neg_q     <= 1'b0;
			r_add_q   <= 1'b0;
			r_end_q   <= 1'b0;
			r_next_q  <= ST_OFF;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_ATTACK:  att_q  <= dur_w;
					CFG_DECAY:   dec_q  <= dur_w;
					CFG_RELEASE: rel_q  <= dur_w;
					CFG_SUSTAIN: sus_q  <= cfg_data[16:0];
					CFG_PHASE:   step_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				SQ_IDLE: begin
					if (accept) begin
						if (s_tuser) begin
							if (ns <= 3'(ST_RELEASE)) begin
								stage_q   <= stage_t'(ns);
								elapsed_q <= '0;
								start_q   <= level_q;
							end
						end else begin
							phase_q   <= phase_q + step_q;
							neg_q     <= phase_q[31];
							op_ramp_q <= 1'b0;
							cnt_q     <= CNTW'(LW);
						end
					end
				end
				SQ_MUL, SQ_DIV: begin
					cnt_q <= cnt_q - CNTW'(1);
				end
				SQ_PRE: begin
					cnt_q <= op_ramp_q ? CNTW'(LW) : CNTW'(QMW);
				end
				SQ_ENV: begin
					if (ramp_go) begin
						elapsed_q <= e_inc;
						op_ramp_q <= 1'b1;
						r_add_q   <= add;
						r_end_q   <= e_end;
						r_next_q  <= nxt;
						cnt_q     <= CNTW'(LW);
					end else begin
						unique case (stage_q)
							ST_ATTACK: begin
								level_q   <= FULL;
								stage_q   <= ST_DECAY;
								elapsed_q <= '0;
								start_q   <= FULL;
							end
							ST_DECAY: begin
								level_q   <= sus_lvl;
								stage_q   <= ST_SUSTAIN;
								elapsed_q <= '0;
								start_q   <= sus_lvl;
							end
							ST_SUSTAIN: begin
								level_q <= sus_lvl;
							end
							ST_RELEASE: begin
								level_q   <= '0;
								stage_q   <= ST_OFF;
								elapsed_q <= '0;
								start_q   <= '0;
							end
							default: begin
								level_q <= '0;
							end
						endcase
					end
				end
				SQ_RAMP: begin
					level_q <= lvl_new;
					if (r_end_q) begin
						stage_q   <= r_next_q;
						elapsed_q <= '0;
						start_q   <= lvl_new;
					end
				end
				default: ;
			endcase
		end
	end

	// serial multiply and divide datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			SQ_IDLE: begin
				mr_q <= level_q;
				mc_q <= MBW'(phase_q[31] ? K_NEG : K_POS);
				dv_q <= SAMPLE_DIV;
				p_q  <= '0;
			end
			SQ_MUL: begin
				p_q  <= (p_q << 1) + (mr_q[LW-1] ? PW'(mc_q) : PW'(0));
				mr_q <= mr_q << 1;
			end
			SQ_PRE: begin
				if (op_ramp_q) begin
					rem_q <= VW'(p_q >> LW);
					qs_q  <= {p_q[LW-1:0], {(QMW-LW){1'b0}}};
				end else begin
					rem_q <= VW'(p_q >> QMW);
					qs_q  <= p_q[QMW-1:0];
				end
			end
			SQ_DIV: begin
				rem_q <= ge ? VW'(trial - {1'b0, dv_q}) : trial[VW-1:0];
				qs_q  <= {qs_q[QMW-2:0], ge};
			end
			SQ_ENV: begin
				if (!op_ramp_q) begin
					sample_q <= neg_q ? 32'd0 - qs_q : qs_q;
				end
				mr_q <= span;
				mc_q <= MBW'(e_use);
				dv_q <= VW'(dur);
				p_q  <= '0;
			end
			SQ_FIN: begin
				if (out_load) begin
					m_data_q <= {stage_q, sample_q};
				end
			end
			default: ;
		endcase
	end

endmodule

### tb/tb_adsr_square_wave_generator_top.sv
// testbench for the adsr square wave generator: queued words, shadow envelope, stream check
module tb_adsr_square_wave_generator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import adsr_pkg::*;

	localparam int LVL_BITS = 16;
	localparam logic [63:0] FULL = 64'd1 << LVL_BITS;
	localparam logic [23:0] DUR_MAX = 24'hFFFFFF;
	localparam bit FN_TICK = 1'b0;
	localparam bit FN_SET = 1'b1;
	localparam logic [2:0] CODE_BAD_LO = 3'd5;
	localparam logic [2:0] CODE_BAD_HI = 3'd7;
	localparam int LIMIT = 800000;
	localparam int SETTLE = 200;
	localparam int LONG_HOLD = 3000;

	typedef struct packed {
		bit         func;
		logic [2:0] code;
	} word_t;

	typedef struct packed {
		logic [31:0] sample;
		logic [2:0]  stage;
	} sample_t;

	typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE} rdy_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [39:0]          m_tdata;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	adsr_square_wave_generator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	word_t   stim_q[$];
	sample_t sample_q[$];
	int      errors = 0;
	int      n_results = 0;
	int      n_pushed = 0;
	int      n_taken = 0;
	int      n_counted = 0;
	int      burst_left = 1;
	int      gap_left = 0;
	int      hold_left = 0;
	bit      held_long = 1'b0;
	rdy_mode_t mode = RDY_ALWAYS;
	int      mode_left = 0;
	int      cycles = 0;

	// shadow registers and envelope state
	logic [23:0] sh_attack = 24'd960;
	logic [23:0] sh_decay = 24'd960;
	logic [23:0] sh_release = 24'd38400;
	logic [16:0] sh_sustain = 17'd65536;
	logic [31:0] sh_step = 32'd4921317;
	stage_t      env = ST_OFF;
	logic [16:0] lvl = '0;
	logic [16:0] lvl_start = '0;
	logic [23:0] elapsed = '0;
	logic [31:0] phase = '0;

	function automatic logic [63:0] ramp(input logic [63:0] span, input logic [63:0] e,
			input logic [63:0] d);
		if (e > d)
			e = d;
		return span * e / d;
	endfunction

	function automatic logic [63:0] sus_level();
		return (sh_sustain > FULL) ? FULL : 64'(sh_sustain);
	endfunction

	task automatic enter_stage(input stage_t s);
		env = s;
		elapsed = '0;
		lvl_start = lvl;
	endtask

	task automatic bump_elapsed();
		if (elapsed < DUR_MAX)
			elapsed = elapsed + 24'd1;
	endtask

	task automatic decay_step();
		logic [63:0] sus;
		sus = sus_level();
		if (sh_decay != '0) begin
			bump_elapsed();
			if (lvl_start >= sus)
				lvl = 17'(lvl_start - ramp(lvl_start - sus, elapsed, sh_decay));
			else
				lvl = 17'(lvl_start + ramp(sus - lvl_start, elapsed, sh_decay));
		end else begin
			lvl = 17'(sus);
		end
		if (elapsed >= sh_decay)
			enter_stage(ST_SUSTAIN);
	endtask

	task automatic envelope_step();
		case (env)
			ST_ATTACK: begin
				if (sh_attack != '0) begin
					bump_elapsed();
					lvl = 17'(lvl_start + ramp(FULL - lvl_start, elapsed, sh_attack));
					if (elapsed >= sh_attack)
						enter_stage(ST_DECAY);
				end else begin
					// instant attack runs straight into decay
					lvl = 17'(FULL);
					enter_stage(ST_DECAY);
					decay_step();
				end
			end
			ST_DECAY: decay_step();
			ST_SUSTAIN: lvl = 17'(sus_level());
			ST_RELEASE: begin
				if (sh_release != '0) begin
					bump_elapsed();
					lvl = 17'(lvl_start - ramp(lvl_start, elapsed, sh_release));
				end else begin
					lvl = '0;
				end
				if (elapsed >= sh_release)
					enter_stage(ST_OFF);
			end
			default: lvl = '0;
		endcase
	endtask

	task automatic tone_step(input bit func, input logic [2:0] code, output bit has_res,
			output sample_t res);
		logic [63:0] mag;
		has_res = 1'b0;
		res = '0;
		if (func == FN_SET) begin
			if (code <= ST_RELEASE)
				enter_stage(stage_t'(code));
		end else begin
			if (phase < 32'h8000_0000) begin
				mag = 64'd2147483647 * 64'd3 * lvl / (64'd10 << LVL_BITS);
				res.sample = mag[31:0];
			end else begin
				mag = 64'd2147483648 * 64'd3 * lvl / (64'd10 << LVL_BITS);
				res.sample = 32'd0 - mag[31:0];
			end
			phase = phase + sh_step;
			envelope_step();
			res.stage = env;
			has_res = 1'b1;
		end
	endtask

	always @(posedge clk) begin : drive_words
		bit      nv;
		bit      has_res;
		sample_t res;
		word_t   w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			nv = s_tvalid;
			if (s_tvalid && s_tready) begin
				tone_step(s_tuser, s_tdata[2:0], has_res, res);
				if (has_res)
					sample_q.push_back(res);
				n_taken++;
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (stim_q.size() > 0) begin
					w = stim_q.pop_front();
					s_tuser <= w.func;
					s_tdata <= {5'b0, w.code};
					nv = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
			s_tvalid <= nv;
		end
	end

	always @(posedge clk) begin : check_words
		sample_t want;
		bit      rdy;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (sample_q.size() == 0) begin
					errors++;
					$error("unexpected word: sample %0d stage %0d", $signed(m_tdata[31:0]),
						m_tdata[34:32]);
				end else begin
					want = sample_q.pop_front();
					if (m_tdata[31:0] !== want.sample) begin
						errors++;
						$error("sample: expected %0d, got %0d", $signed(want.sample),
							$signed(m_tdata[31:0]));
					end
					if (m_tdata[34:32] !== want.stage) begin
						errors++;
						$error("stage: expected %0d, got %0d", want.stage, m_tdata[34:32]);
					end
				end
			end
			// one long hold-off while words keep coming, to back the block up
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (!held_long && n_results >= 120 && stim_q.size() > 20) begin
				held_long = 1'b1;
				hold_left = LONG_HOLD;
				rdy = 1'b0;
			end else begin
				if (mode_left > 0) begin
					mode_left--;
				end else begin
					mode = rdy_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 300);
				end
				case (mode)
					RDY_ALWAYS: rdy = 1'b1;
					RDY_HALF: rdy = 1'($urandom_range(0, 1));
					default: rdy = ($urandom_range(0, 3) == 0);
				endcase
			end
			m_tready <= rdy;
		end
	end

	task automatic push_word(input bit func, input logic [2:0] code);
		stim_q.push_back(word_t'{func, code});
		n_pushed++;
		if (func == FN_TICK || code <= ST_RELEASE)
			n_counted++;
	endtask

	task automatic ticks(input int n);
		repeat (n) push_word(FN_TICK, 3'($urandom()));
	endtask

	task automatic wait_drained();
		while (n_taken != n_pushed || sample_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_ATTACK: sh_attack = val[23:0];
			CFG_DECAY: sh_decay = val[23:0];
			CFG_RELEASE: sh_release = val[23:0];
			CFG_SUSTAIN: sh_sustain = val[16:0];
			CFG_PHASE: sh_step = val;
			default: ;
		endcase
	endtask

	// upper bits of the data bus are junk that the block must ignore
	task automatic set_regs(input logic [23:0] a, input logic [23:0] d, input logic [23:0] r,
			input logic [16:0] sus, input logic [31:0] step);
		write_reg(CFG_ATTACK, {8'($urandom()), a});
		write_reg(CFG_DECAY, {8'($urandom()), d});
		write_reg(CFG_RELEASE, {8'($urandom()), r});
		write_reg(CFG_SUSTAIN, {15'($urandom()), sus});
		write_reg(CFG_PHASE, step);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [23:0] rand_dur();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 24'($urandom_range(13, 200));
			default: return 24'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [16:0] rand_sus();
		case ($urandom_range(0, 5))
			0: return 17'($urandom_range(65537, 131071));
			1: return 17'd65536;
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	initial begin : stimulus
		int want_n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings
		ticks(1);
		push_word(FN_SET, ST_ATTACK);
		ticks(1);
		wait_drained();

		// full envelope, upward decay from silence, bad stage codes
		set_regs(24'd3, 24'd2, 24'd3, 17'd40000, 32'h4000_0000);
		push_word(FN_SET, ST_ATTACK);
		ticks(6);
		push_word(FN_SET, ST_RELEASE);
		ticks(3);
		push_word(FN_SET, ST_DECAY);
		ticks(2);
		push_word(FN_SET, CODE_BAD_LO);
		push_word(FN_SET, CODE_BAD_HI);
		wait_drained();

		// instant stages, sustain above full
		set_regs('0, '0, '0, 17'h1FFFF, 32'hFFFF_FFFF);
		push_word(FN_SET, ST_ATTACK);
		ticks(1);
		push_word(FN_SET, ST_RELEASE);
		ticks(1);
		wait_drained();

		// attack shortened part way through
		set_regs(24'd50, 24'd4, 24'd6, 17'd0, 32'd0);
		push_word(FN_SET, ST_ATTACK);
		ticks(2);
		wait_drained();
		set_regs(24'd2, 24'd4, 24'd6, 17'd0, 32'd0);
		ticks(2);

		for (int p = 0; p < 8; p++) begin
			wait_drained();
			case (p)
				0: set_regs('0, '0, '0, '0, '0);
				1: set_regs(DUR_MAX, DUR_MAX, DUR_MAX, 17'h1FFFF, 32'hFFFF_FFFF);
				default: set_regs(rand_dur(), rand_dur(), rand_dur(), rand_sus(), $urandom());
			endcase
			want_n = n_counted + 50;
			while (n_counted < want_n) begin
				if ($urandom_range(0, 9) < 7) begin
					push_word(FN_SET, ST_ATTACK);
					ticks($urandom_range(1, 24));
					push_word(FN_SET, ST_RELEASE);
					ticks($urandom_range(1, 16));
				end else begin
					repeat ($urandom_range(1, 4))
						push_word(1'($urandom_range(0, 1)), 3'($urandom()));
				end
			end
		end

		wait_drained();
		if (errors == 0 && sample_q.size() == 0)
			$display("tb_adsr_square_wave_generator_top: done, clean");
		else
			$display("tb_adsr_square_wave_generator_top: done, errors");
		$finish;
	end

	initial begin : watchdog
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_adsr_square_wave_generator_top: done, errors");
		$finish;
	end

endmodule
